// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the scheduler unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define RRTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rrts assertion failed");
// Check that a condition never occurs outside reset.
`define RRTS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rrts forbidden condition seen");
`else
`define RRTS_ASSERT(label, clk, rst, prop)
`define RRTS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== design/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin thread scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   localparam int FIELD_SLOT_W = 4;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_YIELD  = 2'd1,
      OP_JOIN   = 2'd2,
      OP_EXIT   = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      SLOT_DEAD     = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_RUNNING  = 2'd2,
      SLOT_BLOCKED  = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      req_op_type              req_type;
      logic [FIELD_SLOT_W-1:0] join_target;
   } req_beat_type;

   typedef struct packed {
      logic                    status;
      logic [FIELD_SLOT_W-1:0] new_slot;
      logic [FIELD_SLOT_W-1:0] next_running;
      logic                    restore_saved;
   } rsp_beat_type;

   // One slot table entry as stored in the table RAM.
   typedef struct packed {
      slot_state_type          st;
      logic                    pending;
      logic [FIELD_SLOT_W-1:0] join_slot;
      logic                    first_run;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Verdict of the slot evaluator on one entry.
   typedef struct packed {
      logic dead;
      logic pick;
      logic wake;
   } eval_type;

endpackage

`default_nettype wire

// ===== design/round_robin_thread_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_unit
// Thread slot table with create, yield, join and exit requests.
// ---------------------------------------------------------------------------
// Usage:
//  - Issue a request beat on req_data with start; it is taken at an edge where
//    busy is low. busy stays high until the request is done.
//  - Each request answers with one beat on rsp_data, flagged by rsp_valid for
//    a single cycle. The receiver cannot hold it off; capture it that cycle.
//  - Scan: the table sits in a one-port-read RAM, and one slot entry is
//    read and classified per cycle by the shared slot evaluator. Create walks
//    all NUM_SLOTS entries, the other requests the NUM_SLOTS-1 entries besides
//    the running slot. After the scan a finish step registers the response.
//  - Back to back: busy drops while the response is shown, so the next
//    request can be taken at the edge that ends the response cycle.
//  - Reset: slot 0 runs, every other slot is dead, all first-run marks set.
//    Table entries never written since reset read as these values through
//    per-entry valid bits, so no clearing pass is needed.
//  - The running slot's first-run mark lives in a register; its RAM copy is
//    refreshed whenever the slot gives up the processor.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module round_robin_thread_scheduler_unit #(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire rrts_pkg::req_beat_type req_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output rrts_pkg::rsp_beat_type      rsp_data
);

   import rrts_pkg::*;

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int PW = (IW > FIELD_SLOT_W) ? IW : FIELD_SLOT_W;

   // control state
   seq_state_type          seq_ff, seq_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic                   cur_first_ff, cur_first_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [CW-1:0]          left_ff, left_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload state
   req_op_type             op_ff, op_in;
   logic [IW-1:0]          addr_ff, addr_in;
   logic [IW-1:0]          rd_tag_ff, rd_tag_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IW-1:0]          found_slot_ff, found_slot_in;
   logic                   found_first_ff, found_first_in;
   rsp_beat_type           rsp_data_ff, rsp_data_in;

   // table RAM port
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   entry_type              wr_entry;
   logic                   rd_en;
   logic [ENTRY_W-1:0]     rd_word;

   entry_type              seen;
   eval_type               verdict;
   logic                   hit;
   logic                   accept;
   logic [IW-1:0]          next_slot;
   logic [IW-1:0]          cur_succ;
   logic [IW-1:0]          addr_succ;
   logic [PW-1:0]          pad_new;
   logic [PW-1:0]          pad_next;
   logic [PW-1:0]          pad_cur;

   rrts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   // An entry never written since reset reads as its reset value.
   always_comb begin
      if (rd_valid_ff) begin
         seen = entry_type'(rd_word);
      end else begin
         seen.st        = (rd_tag_ff == '0) ? SLOT_RUNNING : SLOT_DEAD;
         seen.pending   = 1'b0;
         seen.join_slot = '0;
         seen.first_run = 1'b1;
      end
   end

   rrts_slot_eval #(
      .SLOT_W (IW)
   ) u_eval (
      .entry   (seen),
      .tag     (rd_tag_ff),
      .cur     (cur_ff),
      .op      (op_ff),
      .verdict (verdict)
   );

   assign hit    = (op_ff == OP_CREATE) ? verdict.dead : verdict.pick;
   assign accept = start && (seq_ff == SEQ_IDLE);
   assign busy   = (seq_ff != SEQ_IDLE);

   // wrap slot numbers modulo NUM_SLOTS
   assign cur_succ  = (cur_ff == IW'(NUM_SLOTS - 1)) ? '0 : cur_ff + 1'b1;
   assign addr_succ = (addr_ff == IW'(NUM_SLOTS - 1)) ? '0 : addr_ff + 1'b1;

   // no runnable slot found: keep the current slot
   assign next_slot = found_ff ? found_slot_ff : cur_ff;
   assign pad_new   = PW'(found_slot_ff);
   assign pad_next  = PW'(next_slot);
   assign pad_cur   = PW'(cur_ff);

   // next state of the sequencer
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (start) begin
               seq_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            // the last read is classified in the cycle left hits zero
            if (left_ff == '0) begin
               seq_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            seq_in = SEQ_IDLE;
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // datapath and table port control
   always_comb begin
      op_in          = op_ff;
      cur_in         = cur_ff;
      cur_first_in   = cur_first_ff;
      left_in        = left_ff;
      addr_in        = addr_ff;
      rd_pend_in     = 1'b0;
      rd_tag_in      = rd_tag_ff;
      rd_valid_in    = rd_valid_ff;
      found_in       = found_ff;
      found_slot_in  = found_slot_ff;
      found_first_in = found_first_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;
      valid_in       = valid_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_entry       = '0;
      rd_en          = 1'b0;

      case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               op_in     = req_data.req_type;
               found_in  = 1'b0;
               if (req_data.req_type == OP_CREATE) begin
                  addr_in = '0;
                  left_in = CW'(NUM_SLOTS);
               end else begin
                  addr_in = cur_succ;
                  left_in = CW'(NUM_SLOTS - 1);
                  // write back the slot that gives up the processor
                  wr_en              = 1'b1;
                  wr_addr            = cur_ff;
                  wr_entry.first_run = cur_first_ff;
                  case (req_data.req_type)
                     OP_YIELD: begin
                        wr_entry.st = SLOT_RUNNABLE;
                     end
                     OP_JOIN: begin
                        wr_entry.st        = SLOT_BLOCKED;
                        wr_entry.pending   = 1'b1;
                        wr_entry.join_slot = req_data.join_target;
                     end
                     default: begin
                        wr_entry.st = SLOT_DEAD;
                     end
                  endcase
               end
            end
         end

         SEQ_SCAN: begin
            // issue: one entry read per cycle
            if (left_ff != '0) begin
               rd_en       = 1'b1;
               rd_pend_in  = 1'b1;
               rd_tag_in   = addr_ff;
               rd_valid_in = valid_ff[addr_ff];
               addr_in     = addr_succ;
               left_in     = left_ff - 1'b1;
            end
            // classify the entry read last cycle
            if (rd_pend_ff) begin
               if (hit && !found_ff) begin
                  found_in       = 1'b1;
                  found_slot_in  = rd_tag_ff;
                  found_first_in = seen.first_run;
               end
               if (verdict.wake) begin
                  wr_en              = 1'b1;
                  wr_addr            = rd_tag_ff;
                  wr_entry           = seen;
                  wr_entry.st        = SLOT_RUNNABLE;
                  wr_entry.pending   = 1'b0;
               end
            end
         end

         SEQ_FINISH: begin
            rsp_valid_in = 1'b1;
            cur_first_in = 1'b0;
            if (op_ff == OP_CREATE) begin
               rsp_data_in.status        = !found_ff;
               rsp_data_in.new_slot      = found_ff ? pad_new[FIELD_SLOT_W-1:0] : '0;
               rsp_data_in.next_running  = pad_cur[FIELD_SLOT_W-1:0];
               rsp_data_in.restore_saved = 1'b1;
               if (found_ff) begin
                  wr_en              = 1'b1;
                  wr_addr            = found_slot_ff;
                  wr_entry.st        = SLOT_RUNNABLE;
                  wr_entry.first_run = 1'b1;
               end
            end else begin
               rsp_data_in.status        = 1'b0;
               rsp_data_in.new_slot      = '0;
               rsp_data_in.next_running  = pad_next[FIELD_SLOT_W-1:0];
               rsp_data_in.restore_saved = found_ff ? !found_first_ff : !cur_first_ff;
               // enter the chosen slot
               wr_en       = 1'b1;
               wr_addr     = next_slot;
               wr_entry.st = SLOT_RUNNING;
               cur_in      = next_slot;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         cur_ff       <= '0;
         cur_first_ff <= 1'b1;
         valid_ff     <= '0;
         left_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         cur_ff       <= cur_in;
         cur_first_ff <= cur_first_in;
         valid_ff     <= valid_in;
         left_ff      <= left_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      rd_tag_ff      <= rd_tag_in;
      rd_valid_ff    <= rd_valid_in;
      found_slot_ff  <= found_slot_in;
      found_first_ff <= found_first_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the response beat is only shown once the sequencer is back at idle
   `RRTS_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid_ff |-> (seq_ff == SEQ_IDLE))
   // a taken request keeps the block busy in the next cycle
   `RRTS_ASSERT(a_accept_busy, clock, reset, accept |=> busy)
   // only slot 0, before it ever gave up the processor, may still be on first run
   `RRTS_ASSERT(a_first_run_slot0, clock, reset, cur_first_ff |-> (cur_ff == '0))
   // a failed create reports no slot
   `RRTS_ASSERT_NEVER(a_fail_slot, clock, reset, rsp_valid && rsp_data.status && |rsp_data.new_slot)
   // a scan hit is not lost before the finish step
   `RRTS_ASSERT(a_found_holds, clock, reset, (found_ff && (seq_ff == SEQ_SCAN)) |=> found_ff)

endmodule

`default_nettype wire

// ===== design/rrts_ram.sv =====
// ---------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rrts_slot_eval.sv =====
// ---------------------------------------------------------------------------
// rrts_slot_eval
// Shared compare unit: classifies one table entry during a scan.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_slot_eval #(
   parameter int SLOT_W = 4
) (
   input  wire rrts_pkg::entry_type  entry,
   input  wire logic [SLOT_W-1:0]    tag,
   input  wire logic [SLOT_W-1:0]    cur,
   input  wire rrts_pkg::req_op_type op,
   output rrts_pkg::eval_type        verdict
);

   import rrts_pkg::*;

   localparam int PW = (SLOT_W > FIELD_SLOT_W) ? SLOT_W : FIELD_SLOT_W;

   logic skip_zero;
   logic joins_cur;

   // yield and join never hand the processor to slot 0
   assign skip_zero = (op != OP_EXIT) && (tag == '0);
   assign joins_cur = entry.pending && (PW'(entry.join_slot) == PW'(cur));

   always_comb begin
      verdict.dead = (entry.st == SLOT_DEAD);
      verdict.wake = (op == OP_EXIT) && joins_cur;
      verdict.pick = !skip_zero && ((entry.st == SLOT_RUNNABLE) || verdict.wake);
   end

endmodule

`default_nettype wire
